// ----- rtl/isq_pkg.sv -----
// Package for the indexed sequence store.
// Command codes, payload structs, per-cell control struct and sizing constants.
// No dependencies.
package isq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic                     ok;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } out_t;

  // broadcast to every cell
  typedef struct packed {
    logic ins;    // open a gap at the index, load the word
    logic ers;    // close the gap at the index
    logic snap;   // copy data into the read lane
    logic shift;  // move the read lane one cell toward the front
  } cell_cmd_t;

endpackage

// ----- rtl/isq_cell.sv -----
// One entry of the store: a data word and a read-lane word.
// Data moves to/from neighbors on insert/erase; the lane drains toward the front.
// Depends on isq_pkg.
module isq_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  isq_pkg::cell_cmd_t               cmd,
  input  logic [IDX_W-1:0]                 at,
  input  logic signed [isq_pkg::WORD_W-1:0] word,
  input  logic signed [isq_pkg::WORD_W-1:0] left_data,
  input  logic signed [isq_pkg::WORD_W-1:0] right_data,
  input  logic signed [isq_pkg::WORD_W-1:0] right_lane,
  output logic signed [isq_pkg::WORD_W-1:0] data,
  output logic signed [isq_pkg::WORD_W-1:0] lane
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [isq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic signed [isq_pkg::WORD_W-1:0] lane_r, lane_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && (MY_IDX > at)) begin
      data_nxt = left_data;
    end else if (cmd.ins && (MY_IDX == at)) begin
      data_nxt = word;
    end else if (cmd.ers && (MY_IDX >= at)) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    lane_nxt = lane_r;
    if (cmd.snap) begin
      lane_nxt = data_r;
    end else if (cmd.shift) begin
      lane_nxt = right_lane;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    lane_r <= lane_nxt;
  end

  assign data = data_r;
  assign lane = lane_r;

endmodule

// ----- rtl/indexed_sequence_store.sv -----
// Indexed sequence store: bounded ordered list of signed words in a row of cells.
// Push, pop, insert and erase shift the whole row together. Every command gives one
// result, in the cycle after the transfer, except a successful pop or erase at index k
// above zero: busy is raised while the removed word walks down the read lane toward
// the front cell, and the result is taken from cell one and shown as busy falls.
// The result strobe cannot be stalled; results are taken when shown.
// Depends on isq_pkg and isq_cell.
module indexed_sequence_store #(
  parameter int DEPTH = isq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  isq_pkg::in_t  in_data,
  output logic          out_valid,
  output isq_pkg::out_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > isq_pkg::POS_W) ? CNT_W : isq_pkg::POS_W;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             busy_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;
  isq_pkg::out_t    out_data_r;

  logic signed [isq_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic signed [isq_pkg::WORD_W-1:0] cell_lane [DEPTH];

  logic               accept;
  logic [CMP_W-1:0]   fill_e, pos_e, at_e, fill_after;
  logic               full, ins, ers, clr, ok;
  isq_pkg::cell_cmd_t cmd;

  assign accept = start && !busy_r;
  assign fill_e = CMP_W'(fill_r);
  assign pos_e  = CMP_W'(in_data.position);
  assign full   = (fill_e >= CMP_W'(DEPTH));

  always_comb begin
    ins  = 1'b0;
    ers  = 1'b0;
    clr  = 1'b0;
    at_e = '0;
    unique case (in_data.op)
      isq_pkg::OP_PUSH_FRONT: begin
        ins = !full;
      end
      isq_pkg::OP_PUSH_BACK: begin
        ins  = !full;
        at_e = fill_e;
      end
      isq_pkg::OP_POP_FRONT: begin
        ers = (fill_e != '0);
      end
      isq_pkg::OP_POP_BACK: begin
        ers  = (fill_e != '0);
        at_e = fill_e - CMP_W'(1);
      end
      isq_pkg::OP_INSERT: begin
        ins  = !full && (pos_e <= fill_e);
        at_e = pos_e;
      end
      isq_pkg::OP_ERASE: begin
        ers  = (pos_e < fill_e);
        at_e = pos_e;
      end
      isq_pkg::OP_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ok = ins || ers || clr;

  always_comb begin
    fill_after = fill_e;
    if (clr) begin
      fill_after = '0;
    end else if (ins) begin
      fill_after = fill_e + CMP_W'(1);
    end else if (ers) begin
      fill_after = fill_e - CMP_W'(1);
    end
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = fill_after[CNT_W-1:0];
    end
  end

  assign cmd.ins   = accept && ins;
  assign cmd.ers   = accept && ers;
  assign cmd.snap  = accept && ers;
  assign cmd.shift = busy_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [isq_pkg::WORD_W-1:0] left_d, right_d, right_l;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
      assign right_l = cell_lane[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
      assign right_l = cell_lane[i+1];
    end
    isq_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .at         (at_e[IDX_W-1:0]),
      .word       (in_data.word_in),
      .left_data  (left_d),
      .right_data (right_d),
      .right_lane (right_l),
      .data       (cell_data[i]),
      .lane       (cell_lane[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= 1'b0;
      if (accept) begin
        out_data_r.ok       <= ok;
        out_data_r.count    <= fill_after[isq_pkg::COUNT_W-1:0];
        out_data_r.is_empty <= (fill_after == '0);
        out_data_r.word_out <= '0;
        if (ers && (at_e != '0)) begin
          busy_r <= 1'b1;
          cnt_r  <= at_e[IDX_W-1:0];
        end else begin
          out_valid_r <= 1'b1;
          if (ers) begin
            out_data_r.word_out <= cell_data[0];
          end
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - IDX_W'(1);
        if (cnt_r == IDX_W'(1)) begin
          busy_r              <= 1'b0;
          out_valid_r         <= 1'b1;
          out_data_r.word_out <= cell_lane[1];
        end
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_result_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result shown while a removal is in flight");

  a_busy_ends_in_result : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("removal finished without a result");

  a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= CMP_W'(DEPTH))
    else $error("fill beyond depth");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == isq_pkg::OP_CLEAR)) |=>
      (out_valid_r && out_data_r.is_empty && out_data_r.ok))
    else $error("clear did not report an empty store");

endmodule
